### hw/rtl/aatm_pkg.sv
// Shared types and constants of the ASCII-art tile matcher.
package aatm_pkg;

  localparam int CfgDataW = 13;
  localparam int CfgIdxW  = 2;
  localparam int SumW     = 20;
  localparam int LevelW   = 16;
  localparam int LumaW    = 8;
  localparam int OutIdxW  = 6;
  localparam int QueueDepth = 4;

  localparam int ImageWidthRst  = 640;
  localparam int BlockWidthRst  = 8;
  localparam int BlockHeightRst = 16;
  localparam int GlyphCountRst  = 58;
  localparam int ImageWidthMax  = 4096;
  localparam int BlockMax       = 64;

  // Q0.16 luma weights
  localparam logic [15:0] WeightBlue  = 16'd7502;
  localparam logic [15:0] WeightGreen = 16'd38444;
  localparam logic [15:0] WeightRed   = 16'd19589;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH,
    REG_BLOCK_WIDTH,
    REG_BLOCK_HEIGHT,
    REG_GLYPH_COUNT
  } aatm_reg_e;

  typedef enum logic {
    OP_PIXEL,
    OP_TABLE
  } aatm_op_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_ADD,
    FR_SWEEP,
    FR_TBL,
    FR_DIV_N,
    FR_DIV_T
  } aatm_front_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SEARCH,
    BK_EMIT
  } aatm_back_e;

  // clamped geometry seen by the front
  typedef struct packed {
    logic [12:0] width;
    logic [6:0]  bwidth;
    logic [6:0]  bheight;
  } aatm_geom_t;

  // one tile handed from front to back
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic            row_end;
    logic            run_last;
  } aatm_tile_t;

endpackage

### hw/rtl/ascii_art_tile_matcher.sv
// Top level of the ASCII-art tile matcher: config registers, front, queue, back, glyph RAM.
//
// Input channel (push/full): pixel beats in raster order, or table-write beats
// that load one glyph level. full stays high while the front is busy with a
// beat; a table write also waits until every queued tile has been matched.
// When a block row completes (or last_pixel is seen) the front flushes one
// tile sum per cycle into a 4-entry queue while the queue has room, up to
// MAX_TILE_COLS sums per row. Result channel (empty/pop): one beat per tile
// with the nearest glyph index. For each tile the back takes it from the
// queue, divides for the mean, searches the glyph table and loads the result
// register before it takes the next tile.
// A write to image_width or block_width, seen while the front is idle,
// re-derives the tile count and the current tile position with two divider
// runs; full stays high meanwhile.
// Reset clears the tile sums, position counters and all config registers to
// their defaults; glyph levels must be written before use.
// A stalled receiver holds the result register; the back stops, the queue
// fills, and the front raises full during its next row flush.
module ascii_art_tile_matcher #(
  parameter int MAX_TILE_COLS = 32,
  parameter int TABLE_DEPTH   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              opcode_i,
  input  logic [7:0]                        blue_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        red_i,
  input  logic                              last_pixel_i,
  input  logic [5:0]                        entry_index_i,
  input  logic [15:0]                       entry_level_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [5:0]                        glyph_index_o,
  output logic                              row_end_o,
  output logic                              run_last_o,
  input  logic                              cfg_we_i,
  input  logic [aatm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [aatm_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [12:0] iw_q;
  logic [6:0]  bw_q;
  logic [6:0]  bh_q;
  logic [6:0]  gc_q;
  logic        recalc_q;
  logic [12:0] area_q;

  aatm_pkg::aatm_geom_t geom;
  logic [CW-1:0]        gcount;
  aatm_pkg::aatm_reg_e  cfg_reg;

  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  aatm_pkg::aatm_tile_t q_wdata;
  aatm_pkg::aatm_tile_t q_rdata;
  logic                 bk_idle;
  logic                 tbl_we;
  logic [AW-1:0]        tbl_addr;
  logic [15:0]          tbl_data;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [15:0]          rd_data;

  assign cfg_reg = aatm_pkg::aatm_reg_e'(cfg_idx_i);

  always_comb begin
    geom.width   = (iw_q == '0) ? 13'd1 :
                   (iw_q > 13'(aatm_pkg::ImageWidthMax)) ? 13'(aatm_pkg::ImageWidthMax) : iw_q;
    geom.bwidth  = (bw_q == '0) ? 7'd1 : (bw_q > 7'(aatm_pkg::BlockMax)) ? 7'(aatm_pkg::BlockMax) : bw_q;
    geom.bheight = (bh_q == '0) ? 7'd1 : (bh_q > 7'(aatm_pkg::BlockMax)) ? 7'(aatm_pkg::BlockMax) : bh_q;
    gcount       = (gc_q == '0) ? CW'(1) :
                   (int'(gc_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(gc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q     <= 13'(aatm_pkg::ImageWidthRst);
      bw_q     <= 7'(aatm_pkg::BlockWidthRst);
      bh_q     <= 7'(aatm_pkg::BlockHeightRst);
      gc_q     <= 7'(aatm_pkg::GlyphCountRst);
      recalc_q <= 1'b0;
      area_q   <= 13'(aatm_pkg::BlockWidthRst * aatm_pkg::BlockHeightRst);
    end else begin
      recalc_q <= cfg_we_i &&
                  (cfg_reg == aatm_pkg::REG_IMAGE_WIDTH || cfg_reg == aatm_pkg::REG_BLOCK_WIDTH);
      area_q   <= 13'(14'(geom.bwidth) * 14'(geom.bheight));
      if (cfg_we_i) begin
        unique case (cfg_reg)
          aatm_pkg::REG_IMAGE_WIDTH:  iw_q <= cfg_data_i;
          aatm_pkg::REG_BLOCK_WIDTH:  bw_q <= cfg_data_i[6:0];
          aatm_pkg::REG_BLOCK_HEIGHT: bh_q <= cfg_data_i[6:0];
          aatm_pkg::REG_GLYPH_COUNT:  gc_q <= cfg_data_i[6:0];
          default: begin
          end
        endcase
      end
    end
  end

  aatm_front #(
    .MAX_TILE_COLS(MAX_TILE_COLS),
    .TABLE_DEPTH  (TABLE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .last_pixel_i (last_pixel_i),
    .entry_index_i(entry_index_i),
    .entry_level_i(entry_level_i),
    .geom_i       (geom),
    .recalc_i     (recalc_q),
    .back_idle_i  (bk_idle && q_empty),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata),
    .tbl_we_o     (tbl_we),
    .tbl_addr_o   (tbl_addr),
    .tbl_data_o   (tbl_data)
  );

  aatm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  aatm_ram #(
    .WIDTH(16),
    .DEPTH(TABLE_DEPTH)
  ) u_glyph_ram (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_addr),
    .wdata_i(tbl_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  aatm_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .q_data_i     (q_rdata),
    .area_i       (area_q),
    .gcount_i     (gcount),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .idle_o       (bk_idle),
    .empty_o      (empty),
    .pop_i        (pop),
    .glyph_index_o(glyph_index_o),
    .row_end_o    (row_end_o),
    .run_last_o   (run_last_o)
  );

  // queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("tile queue overflow");

  // glyph table only changes once every queued tile has been matched
  a_tbl_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> (q_empty && bk_idle && !rd_en)) else $error("table write during search");

  // every accepted beat makes the front busy and raises full
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full) else $error("front took two beats back to back");

endmodule

### hw/rtl/aatm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aatm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/aatm_div.sv
// Restoring divider, one quotient bit per cycle.
module aatm_div #(
  parameter int NW = 13,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o,
  output logic [DW-1:0] rem_o
);

  localparam int CntW = $clog2(NW + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   dvs_q;
  logic [DW:0]     shift;
  logic [DW:0]     diff;
  logic            ge;

  always_comb begin
    shift = {rem_q, quo_q[NW-1]};
    ge    = shift >= {1'b0, dvs_q};
    diff  = shift - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(NW);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CntW'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : shift[DW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/aatm_fifo.sv
// Short tile queue between front and back.
module aatm_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  aatm_pkg::aatm_tile_t   data_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output aatm_pkg::aatm_tile_t   data_o,
  output logic                   empty_o
);

  localparam int PW = $clog2(aatm_pkg::QueueDepth);

  aatm_pkg::aatm_tile_t mem_q [aatm_pkg::QueueDepth];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [PW:0]   cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o  = cnt_q == (PW + 1)'(aatm_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PW + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

### hw/rtl/aatm_front.sv
// Front: takes items, sums tile luma, flushes rows, writes table, re-derives tiling.
module aatm_front #(
  parameter int MAX_TILE_COLS = 32,
  parameter int TABLE_DEPTH   = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic                               opcode_i,
  input  logic [7:0]                         blue_i,
  input  logic [7:0]                         green_i,
  input  logic [7:0]                         red_i,
  input  logic                               last_pixel_i,
  input  logic [5:0]                         entry_index_i,
  input  logic [aatm_pkg::LevelW-1:0]        entry_level_i,
  input  aatm_pkg::aatm_geom_t               geom_i,
  input  logic                               recalc_i,
  input  logic                               back_idle_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output aatm_pkg::aatm_tile_t               q_data_o,
  output logic                               tbl_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]     tbl_addr_o,
  output logic [aatm_pkg::LevelW-1:0]        tbl_data_o
);

  localparam int TW  = $clog2(MAX_TILE_COLS);
  localparam int NCW = $clog2(MAX_TILE_COLS + 1);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NcolsFull = aatm_pkg::ImageWidthRst / aatm_pkg::BlockWidthRst + 1;
  localparam int NcolsRst  = (NcolsFull > MAX_TILE_COLS) ? MAX_TILE_COLS : NcolsFull;
  localparam int SW = aatm_pkg::SumW;

  aatm_pkg::aatm_front_e state_q, state_d;

  logic [SW-1:0]   sums_q [MAX_TILE_COLS];
  logic [aatm_pkg::LumaW-1:0] luma_q;
  logic            last_q;
  logic [5:0]      tidx_q;
  logic [aatm_pkg::LevelW-1:0] tlevel_q;
  logic [11:0]     pc_q, pc_d;
  logic [11:0]     tile_q, tile_d;
  logic [5:0]      off_q, off_d;
  logic [5:0]      row_q, row_d;
  logic [NCW-1:0]  ncols_q, ncols_d;
  logic [TW-1:0]   s_q, s_d;
  logic            more_q, more_d;

  logic            accept;
  logic [23:0]     wsum;
  logic [12:0]     pc_inc;
  logic            wrap;
  logic [6:0]      row_inc;
  logic            comp;
  logic            tile_ok;
  logic            sum_we;
  logic [SW-1:0]   sum_add;
  logic            last_tile;
  logic            clear_all;
  logic            div_start;
  logic [12:0]     div_dividend;
  logic [12:0]     div_q;
  logic [6:0]      div_r;
  logic            div_done;
  logic [13:0]     ncols_calc;

  aatm_div #(
    .NW(13),
    .DW(7)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (geom_i.bwidth),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  assign full_o = (state_q != aatm_pkg::FR_IDLE) || recalc_i;
  assign accept = push_i && !full_o;

  always_comb begin
    wsum = 24'(aatm_pkg::WeightBlue) * 24'(blue_i)
         + 24'(aatm_pkg::WeightGreen) * 24'(green_i)
         + 24'(aatm_pkg::WeightRed) * 24'(red_i);
    pc_inc     = 13'(pc_q) + 13'd1;
    wrap       = pc_inc >= geom_i.width;
    row_inc    = 7'(row_q) + 7'd1;
    comp       = wrap && (row_inc >= geom_i.bheight);
    tile_ok    = tile_q < 12'(ncols_q);
    sum_add    = sums_q[tile_q[TW-1:0]] + SW'(luma_q);
    last_tile  = NCW'(s_q) == ncols_q - NCW'(1);
    ncols_calc = 14'(div_q) + 14'd1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aatm_pkg::FR_IDLE: begin
        if (recalc_i) begin
          state_d = aatm_pkg::FR_DIV_N;
        end else if (accept) begin
          state_d = (opcode_i == aatm_pkg::OP_TABLE) ? aatm_pkg::FR_TBL : aatm_pkg::FR_ADD;
        end
      end
      aatm_pkg::FR_ADD: begin
        state_d = (comp || last_q) ? aatm_pkg::FR_SWEEP : aatm_pkg::FR_IDLE;
      end
      aatm_pkg::FR_SWEEP: begin
        if (q_push_o && last_tile && !more_q) begin
          state_d = aatm_pkg::FR_IDLE;
        end
      end
      aatm_pkg::FR_TBL: begin
        if (back_idle_i) begin
          state_d = aatm_pkg::FR_IDLE;
        end
      end
      aatm_pkg::FR_DIV_N: begin
        if (div_done) begin
          state_d = aatm_pkg::FR_DIV_T;
        end
      end
      aatm_pkg::FR_DIV_T: begin
        if (div_done) begin
          state_d = aatm_pkg::FR_IDLE;
        end
      end
      default: state_d = aatm_pkg::FR_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    pc_d         = pc_q;
    tile_d       = tile_q;
    off_d        = off_q;
    row_d        = row_q;
    ncols_d      = ncols_q;
    s_d          = s_q;
    more_d       = more_q;
    sum_we       = 1'b0;
    clear_all    = 1'b0;
    q_push_o     = 1'b0;
    tbl_we_o     = 1'b0;
    div_start    = 1'b0;
    div_dividend = geom_i.width;
    unique case (state_q)
      aatm_pkg::FR_IDLE: begin
        div_start = recalc_i;
      end
      aatm_pkg::FR_ADD: begin
        sum_we = tile_ok;
        more_d = comp && last_q;
        s_d    = '0;
        if (wrap) begin
          pc_d   = '0;
          tile_d = '0;
          off_d  = '0;
          row_d  = comp ? 6'd0 : row_inc[5:0];
        end else begin
          pc_d = pc_inc[11:0];
          if (7'(off_q) + 7'd1 == geom_i.bwidth) begin
            off_d  = '0;
            tile_d = tile_q + 12'd1;
          end else begin
            off_d = off_q + 6'd1;
          end
        end
        if (last_q) begin
          pc_d   = '0;
          tile_d = '0;
          off_d  = '0;
          row_d  = '0;
        end
      end
      aatm_pkg::FR_SWEEP: begin
        q_push_o = !q_full_i;
        if (q_push_o) begin
          if (last_tile) begin
            clear_all = 1'b1;
            s_d       = '0;
            more_d    = 1'b0;
          end else begin
            s_d = s_q + TW'(1);
          end
        end
      end
      aatm_pkg::FR_TBL: begin
        tbl_we_o = back_idle_i && (int'(tidx_q) < TABLE_DEPTH);
      end
      aatm_pkg::FR_DIV_N: begin
        div_dividend = {1'b0, pc_q};
        div_start    = div_done;
        if (div_done) begin
          ncols_d = (ncols_calc > 14'(MAX_TILE_COLS)) ? NCW'(MAX_TILE_COLS) : NCW'(ncols_calc);
        end
      end
      aatm_pkg::FR_DIV_T: begin
        if (div_done) begin
          tile_d = div_q[11:0];
          off_d  = div_r[5:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign q_data_o.sum      = sums_q[s_q];
  assign q_data_o.row_end  = last_tile;
  assign q_data_o.run_last = last_tile && !more_q;
  assign tbl_addr_o        = tidx_q[AW-1:0];
  assign tbl_data_o        = tlevel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aatm_pkg::FR_IDLE;
      pc_q    <= '0;
      tile_q  <= '0;
      off_q   <= '0;
      row_q   <= '0;
      ncols_q <= NCW'(NcolsRst);
      s_q     <= '0;
      more_q  <= 1'b0;
      sums_q  <= '{default: '0};
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      tile_q  <= tile_d;
      off_q   <= off_d;
      row_q   <= row_d;
      ncols_q <= ncols_d;
      s_q     <= s_d;
      more_q  <= more_d;
      if (clear_all) begin
        sums_q <= '{default: '0};
      end else if (sum_we) begin
        sums_q[tile_q[TW-1:0]] <= sum_add;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      luma_q   <= wsum[23:16];
      last_q   <= last_pixel_i;
      tidx_q   <= entry_index_i;
      tlevel_q <= entry_level_i;
    end
  end

endmodule

### hw/rtl/aatm_back.sv
// Back: tile mean by division, nearest glyph level search, result register.
module aatm_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  input  aatm_pkg::aatm_tile_t                q_data_i,
  input  logic [12:0]                         area_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]    gcount_i,
  output logic                                rd_en_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr_o,
  input  logic [aatm_pkg::LevelW-1:0]         rd_data_i,
  output logic                                idle_o,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic [aatm_pkg::OutIdxW-1:0]        glyph_index_o,
  output logic                                row_end_o,
  output logic                                run_last_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = aatm_pkg::LevelW;
  localparam int NW = aatm_pkg::SumW + 8;

  aatm_pkg::aatm_back_e state_q, state_d;

  logic          row_end_q;
  logic          run_last_q;
  logic [LW-1:0] mean_q;
  logic [CW-1:0] i_q;
  logic          cmp_v_q;
  logic [AW-1:0] cmp_idx_q;
  logic [AW-1:0] best_q;
  logic [LW-1:0] best_d_q;
  logic          out_valid_q;
  logic [aatm_pkg::OutIdxW-1:0] gi_q;
  logic          oe_q;
  logic          ol_q;

  logic          div_done;
  logic [NW-1:0] div_q;
  logic [12:0]   div_r;
  logic          issue;
  logic          cmp_last;
  logic          load;
  logic [LW-1:0] lvl_diff;
  logic          better;

  aatm_div #(
    .NW(NW),
    .DW(13)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (q_pop_o),
    .dividend_i({q_data_i.sum, 8'h00}),
    .divisor_i (area_i),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  always_comb begin
    lvl_diff = (rd_data_i > mean_q) ? rd_data_i - mean_q : mean_q - rd_data_i;
    better   = (cmp_idx_q == '0) || (lvl_diff < best_d_q);
    cmp_last = cmp_v_q && (CW'(cmp_idx_q) == gcount_i - CW'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aatm_pkg::BK_IDLE:   if (!q_empty_i) state_d = aatm_pkg::BK_DIV;
      aatm_pkg::BK_DIV:    if (div_done) state_d = aatm_pkg::BK_SEARCH;
      aatm_pkg::BK_SEARCH: if (cmp_last) state_d = aatm_pkg::BK_EMIT;
      aatm_pkg::BK_EMIT:   if (!out_valid_q || pop_i) state_d = aatm_pkg::BK_IDLE;
      default:             state_d = aatm_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o = 1'b0;
    issue   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      aatm_pkg::BK_IDLE:   q_pop_o = !q_empty_i;
      aatm_pkg::BK_SEARCH: issue = i_q < gcount_i;
      aatm_pkg::BK_EMIT:   load = !out_valid_q || pop_i;
      default: begin
      end
    endcase
  end

  assign rd_en_o   = issue;
  assign rd_addr_o = i_q[AW-1:0];
  assign idle_o    = state_q == aatm_pkg::BK_IDLE;
  assign empty_o   = !out_valid_q;
  assign glyph_index_o = gi_q;
  assign row_end_o     = oe_q;
  assign run_last_o    = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aatm_pkg::BK_IDLE;
      cmp_v_q     <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cmp_v_q <= issue;
      if (div_done) begin
        i_q <= '0;
      end else if (issue) begin
        i_q <= i_q + CW'(1);
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      row_end_q  <= q_data_i.row_end;
      run_last_q <= q_data_i.run_last;
    end
    if (div_done) begin
      mean_q <= (div_q > NW'(16'hFFFF)) ? 16'hFFFF : div_q[LW-1:0];
    end
    cmp_idx_q <= i_q[AW-1:0];
    if (cmp_v_q && better) begin
      best_q   <= cmp_idx_q;
      best_d_q <= lvl_diff;
    end
    if (load) begin
      gi_q <= aatm_pkg::OutIdxW'(best_q);
      oe_q <= row_end_q;
      ol_q <= run_last_q;
    end
  end

endmodule
